// ===== hdl/kcache_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kcache_pkg;

    // default sizing
    localparam int CACHE_ENTRIES_DEF = 32;
    localparam int HANDLE_BITS_DEF   = 16;

    // fixed field widths
    localparam int KEY_W   = 64;
    localparam int STAMP_W = 32;
    localparam int HPORT_W = 16;
    localparam int SLOT_W  = 5;
    localparam int MODE_W  = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic start;
        logic cmp_vld;
    } t_scan_ctl;

endpackage

`default_nettype wire

// ===== hdl/kcache_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kcache_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 112
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/kcache_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kcache_scan
    import kcache_pkg::*;
#(
    parameter int ENTRIES     = CACHE_ENTRIES_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire t_scan_ctl                              i_ctl,
    input  wire logic [$clog2(ENTRIES)-1:0]             i_idx,
    input  wire logic [KEY_W+HANDLE_BITS+STAMP_W-1:0]   i_word,
    input  wire logic [KEY_W-1:0]                       i_key,
    output logic                                        o_match,
    output logic                                        o_hit,
    output logic [$clog2(ENTRIES)-1:0]                  o_hit_idx,
    output logic [HANDLE_BITS-1:0]                      o_hit_hnd,
    output logic [$clog2(ENTRIES)-1:0]                  o_old_idx,
    output logic [HANDLE_BITS-1:0]                      o_old_hnd
);

    localparam int IW = $clog2(ENTRIES);
    localparam int WW = KEY_W + HANDLE_BITS + STAMP_W;

    logic [KEY_W-1:0]       w_key;
    logic [HANDLE_BITS-1:0] w_hnd;
    logic [STAMP_W-1:0]     w_stamp;
    logic                   w_older;

    logic                   r_hit;
    logic [IW-1:0]          r_hit_idx;
    logic [HANDLE_BITS-1:0] r_hit_hnd;
    logic [STAMP_W-1:0]     r_old_stamp;
    logic [IW-1:0]          r_old_idx;
    logic [HANDLE_BITS-1:0] r_old_hnd;

    // split the entry word
    assign w_key   = i_word[WW-1 -: KEY_W];
    assign w_hnd   = i_word[STAMP_W +: HANDLE_BITS];
    assign w_stamp = i_word[STAMP_W-1:0];

    // key compare and strictly-older compare, one entry per cycle
    assign o_match = i_ctl.cmp_vld && !r_hit && (w_key == i_key);
    assign w_older = (i_idx == IW'(0)) || (w_stamp < r_old_stamp);

    // hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.start) begin
            r_hit <= 1'b0;
        end else if (o_match) begin
            r_hit <= 1'b1;
        end
    end

    // captured hit and oldest entry
    always_ff @(posedge i_clk) begin
        if (o_match) begin
            r_hit_idx <= i_idx;
            r_hit_hnd <= w_hnd;
        end
        if (i_ctl.cmp_vld && w_older) begin
            r_old_stamp <= w_stamp;
            r_old_idx   <= i_idx;
            r_old_hnd   <= w_hnd;
        end
    end

    assign o_hit     = r_hit;
    assign o_hit_idx = r_hit_idx;
    assign o_hit_hnd = r_hit_hnd;
    assign o_old_idx = r_old_idx;
    assign o_old_hnd = r_old_hnd;

endmodule

`default_nettype wire

// ===== hdl/keyed_cache_with_lru_eviction.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// request   in         i_valid / o_stall    i_mode i_key i_name_handle i_now i_link_up
// result    out        o_valid / i_stall    o_found o_slot o_handle_out o_release_valid
//                                           o_release_handle o_last
//
// lookup and add: the compare unit sees one entry per cycle from the single read port
// of the entry memory, stopping at the first hit.
// clear with link up reads, then emits, one filled entry at a time.
// synchronous active-low reset empties the table; entries are not cleared.
// the request side stalls while a request is in progress; a stalled result holds
// in the output register and the sequencer waits for it before loading the next.

module keyed_cache_with_lru_eviction
    import kcache_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int HANDLE_BITS   = HANDLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [MODE_W-1:0]  i_mode,
    input  wire logic [KEY_W-1:0]   i_key,
    input  wire logic [HPORT_W-1:0] i_name_handle,
    input  wire logic [STAMP_W-1:0] i_now,
    input  wire logic               i_link_up,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_found,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [HPORT_W-1:0]      o_handle_out,
    output logic                    o_release_valid,
    output logic [HPORT_W-1:0]      o_release_handle,
    output logic                    o_last
);

    localparam int IW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    localparam int HB = HANDLE_BITS;
    localparam int WW = KEY_W + HB + STAMP_W;

    localparam int SW = 3;
    localparam logic [SW-1:0] S_IDLE   = 3'd0;
    localparam logic [SW-1:0] S_SCAN   = 3'd1;
    localparam logic [SW-1:0] S_FIN    = 3'd2;
    localparam logic [SW-1:0] S_CLR_RD = 3'd3;
    localparam logic [SW-1:0] S_CLR_WT = 3'd4;

    logic [SW-1:0]      r_state, n_state;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [HB-1:0]      r_hnd, n_hnd;
    logic [STAMP_W-1:0] r_now, n_now;
    logic               r_link, n_link;
    logic [CW-1:0]      r_fill, n_fill;
    logic [IW-1:0]      r_ptr, n_ptr;
    logic               r_iss, n_iss;
    logic               r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]      r_cmp_idx, n_cmp_idx;

    logic               r_o_valid, n_o_valid;
    logic               r_o_found, n_o_found;
    logic [SLOT_W-1:0]  r_o_slot, n_o_slot;
    logic [HPORT_W-1:0] r_o_hout, n_o_hout;
    logic               r_o_rv, n_o_rv;
    logic [HPORT_W-1:0] r_o_rh, n_o_rh;
    logic               r_o_last, n_o_last;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_ptr_last;
    logic               w_cmp_last;
    logic [WW-1:0]      w_rdata;
    t_scan_ctl          w_ctl;
    logic               w_match;
    logic               w_hit;
    logic [IW-1:0]      w_hit_idx;
    logic [HB-1:0]      w_hit_hnd;
    logic [IW-1:0]      w_old_idx;
    logic [HB-1:0]      w_old_hnd;

    logic               w_fin_we;
    logic [IW-1:0]      w_fin_idx;
    logic [WW-1:0]      w_fin_wd;
    logic               w_fin_found;
    logic [HPORT_W-1:0] w_fin_hout;
    logic               w_fin_rv;
    logic [HPORT_W-1:0] w_fin_rh;
    logic               w_fin_grow;
    logic               w_mem_we;

    assign w_in_acc   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_ptr_last = (CW'(r_ptr) + CW'(1)) == r_fill;
    assign w_cmp_last = (CW'(r_cmp_idx) + CW'(1)) == r_fill;

    assign w_ctl.start   = w_in_acc;
    assign w_ctl.cmp_vld = r_cmp_vld;

    // entry memory: {key, handle, stamp}
    kcache_mem #(
        .DEPTH (CACHE_ENTRIES),
        .WIDTH (WW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_fin_idx),
        .i_wdata (w_fin_wd),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    // shared compare unit
    kcache_scan #(
        .ENTRIES     (CACHE_ENTRIES),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_idx     (r_cmp_idx),
        .i_word    (w_rdata),
        .i_key     (r_key),
        .o_match   (w_match),
        .o_hit     (w_hit),
        .o_hit_idx (w_hit_idx),
        .o_hit_hnd (w_hit_hnd),
        .o_old_idx (w_old_idx),
        .o_old_hnd (w_old_hnd)
    );

    // final result and table write of a lookup or add
    always_comb begin
        w_fin_we    = 1'b0;
        w_fin_idx   = w_hit_idx;
        w_fin_wd    = {r_key, r_hnd, r_now};
        w_fin_found = 1'b0;
        w_fin_hout  = '0;
        w_fin_rv    = 1'b0;
        w_fin_rh    = '0;
        w_fin_grow  = 1'b0;
        priority if (r_mode == MODE_LOOKUP) begin
            if (w_hit) begin
                w_fin_we    = 1'b1;
                w_fin_wd    = {r_key, w_hit_hnd, r_now};
                w_fin_found = 1'b1;
                w_fin_hout  = HPORT_W'(w_hit_hnd);
            end
        end else if (r_mode == MODE_ADD) begin
            w_fin_we = 1'b1;
            if (w_hit) begin
                w_fin_found = 1'b1;
            end else if (r_fill < CW'(CACHE_ENTRIES)) begin
                w_fin_idx  = IW'(r_fill);
                w_fin_grow = 1'b1;
            end else begin
                w_fin_idx = w_old_idx;
                w_fin_rv  = r_link;
                w_fin_rh  = r_link ? HPORT_W'(w_old_hnd) : '0;
            end
        end else begin
            w_fin_we = 1'b0;
        end
    end

    assign w_mem_we = (r_state == S_FIN) && w_out_free && w_fin_we;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_hnd     = r_hnd;
        n_now     = r_now;
        n_link    = r_link;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_iss     = r_iss;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_o_valid = r_o_valid && i_stall;
        n_o_found = r_o_found;
        n_o_slot  = r_o_slot;
        n_o_hout  = r_o_hout;
        n_o_rv    = r_o_rv;
        n_o_rh    = r_o_rh;
        n_o_last  = r_o_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mode = i_mode;
                    n_key  = i_key;
                    n_hnd  = HB'(i_name_handle);
                    n_now  = i_now;
                    n_link = i_link_up;
                    n_ptr  = '0;
                    n_iss  = 1'b1;
                    if (i_mode == MODE_CLEAR && i_link_up && r_fill != '0) begin
                        n_state = S_CLR_RD;
                    end else if ((i_mode == MODE_LOOKUP || i_mode == MODE_ADD)
                                 && r_fill != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                // issue one read per cycle, compare it in the next cycle
                if (r_iss) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_ptr;
                    if (w_ptr_last) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ptr = r_ptr + IW'(1);
                    end
                end
                if (r_cmp_vld && (w_match || w_cmp_last)) begin
                    n_state   = S_FIN;
                    n_cmp_vld = 1'b0;
                    n_iss     = 1'b0;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_found = w_fin_found;
                    n_o_slot  = SLOT_W'(w_fin_we ? w_fin_idx : IW'(0));
                    n_o_hout  = w_fin_hout;
                    n_o_rv    = w_fin_rv;
                    n_o_rh    = w_fin_rh;
                    n_o_last  = 1'b1;
                    if (w_fin_grow) begin
                        n_fill = r_fill + CW'(1);
                    end
                    if (r_mode == MODE_CLEAR) begin
                        n_fill = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_CLR_RD: begin
                n_state = S_CLR_WT;
            end
            S_CLR_WT: begin
                // emit one release per filled entry
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_found = 1'b0;
                    n_o_slot  = SLOT_W'(r_ptr);
                    n_o_hout  = '0;
                    n_o_rv    = 1'b1;
                    n_o_rh    = HPORT_W'(w_rdata[STAMP_W +: HB]);
                    n_o_last  = w_ptr_last;
                    if (w_ptr_last) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + IW'(1);
                        n_state = S_CLR_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_iss     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_iss     <= n_iss;
            r_cmp_vld <= n_cmp_vld;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_hnd     <= n_hnd;
        r_now     <= n_now;
        r_link    <= n_link;
        r_ptr     <= n_ptr;
        r_cmp_idx <= n_cmp_idx;
        r_o_found <= n_o_found;
        r_o_slot  <= n_o_slot;
        r_o_hout  <= n_o_hout;
        r_o_rv    <= n_o_rv;
        r_o_rh    <= n_o_rh;
        r_o_last  <= n_o_last;
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_found          = r_o_found;
    assign o_slot           = r_o_slot;
    assign o_handle_out     = r_o_hout;
    assign o_release_valid  = r_o_rv;
    assign o_release_handle = r_o_rh;
    assign o_last           = r_o_last;

endmodule

`default_nettype wire

// ===== hdl/kcache_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kcache_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_found,
    input wire logic [4:0]  o_slot,
    input wire logic [15:0] o_handle_out,
    input wire logic        o_release_valid,
    input wire logic        o_last
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its slot and end mark
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_slot) && $stable(o_last))
        else $error("result changed while stalled");

    // a hit never also releases
    a_found_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> !o_release_valid)
        else $error("hit result carries a release");

    // handle out only on a hit
    a_handle_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_handle_out == 16'd0)
        else $error("handle out without a hit");

    // only clear releases come in runs
    a_run_is_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_release_valid && !o_found)
        else $error("non-final result that is not a release");

endmodule

bind keyed_cache_with_lru_eviction kcache_chk u_kcache_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_found         (o_found),
    .o_slot          (o_slot),
    .o_handle_out    (o_handle_out),
    .o_release_valid (o_release_valid),
    .o_last          (o_last)
);

`default_nettype wire

// ===== test/tb_keyed_cache_with_lru_eviction.sv =====
`timescale 1ns / 1ps

module tb_keyed_cache_with_lru_eviction;
    import kcache_pkg::*;

    localparam int NUM_ENTRIES  = CACHE_ENTRIES_DEF;
    localparam int NUM_DIRECTED = 17;
    localparam int RAND_ITEMS   = 254;
    localparam int KEY_POOL     = 48;
    localparam int HOLD_AT      = 100;
    localparam int PAUSE_AT     = 200;
    localparam int QUIET_AT     = 220;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 120;
    localparam int LIMIT_CYCLES = 1000000;

    // mode value with no operation behind it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [HPORT_W-1:0] handle_out;
        logic               release_valid;
        logic [HPORT_W-1:0] release_handle;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [HPORT_W-1:0] hnd;
        logic [STAMP_W-1:0] now;
        logic               link;
        logic [5:0]         reps;
        logic               use_lit;
        t_result            lit;
    } t_stim_row;

    // lone final result with every other field zero
    localparam t_result DONE_ONLY = '{1'b0, 5'd0, 16'h0, 1'b0, 16'h0, 1'b1};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [MODE_W-1:0]  i_mode;
    logic [KEY_W-1:0]   i_key;
    logic [HPORT_W-1:0] i_name_handle;
    logic [STAMP_W-1:0] i_now;
    logic               i_link_up;
    logic               o_valid;
    logic               i_stall;
    logic               o_found;
    logic [SLOT_W-1:0]  o_slot;
    logic [HPORT_W-1:0] o_handle_out;
    logic               o_release_valid;
    logic [HPORT_W-1:0] o_release_handle;
    logic               o_last;

    keyed_cache_with_lru_eviction dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_key            (i_key),
        .i_name_handle    (i_name_handle),
        .i_now            (i_now),
        .i_link_up        (i_link_up),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_found          (o_found),
        .o_slot           (o_slot),
        .o_handle_out     (o_handle_out),
        .o_release_valid  (o_release_valid),
        .o_release_handle (o_release_handle),
        .o_last           (o_last)
    );

    // shadow copy of the table
    logic [KEY_W-1:0]   tag_mem   [NUM_ENTRIES];
    logic [HPORT_W-1:0] name_mem  [NUM_ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [NUM_ENTRIES];
    int                 used_count;

    t_result   pending_results [$];
    t_stim_row directed_tbl [NUM_DIRECTED];
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    int   error_count;
    int   cycle_count;
    logic hold_off_req;
    logic quiet;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    // expected results of one accepted request, table updated on the way
    task automatic cache_access(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                                input logic [HPORT_W-1:0] hnd, input logic [STAMP_W-1:0] now,
                                input logic link);
        t_result          r;
        int               hit;
        int               victim;
        logic [STAMP_W-1:0] oldest;
        r = DONE_ONLY;
        hit = -1;
        case (mode)
            MODE_LOOKUP: begin
                for (int i = 0; i < used_count; i++)
                    if (hit < 0 && tag_mem[i] == key) hit = i;
                if (hit >= 0) begin
                    stamp_mem[hit] = now;
                    r.found = 1'b1;
                    r.slot = SLOT_W'(hit);
                    r.handle_out = name_mem[hit];
                end
                pending_results.push_back(r);
            end
            MODE_ADD: begin
                for (int i = 0; i < used_count; i++)
                    if (hit < 0 && tag_mem[i] == key) hit = i;
                if (hit >= 0) begin
                    // update in place
                    name_mem[hit] = hnd;
                    stamp_mem[hit] = now;
                    r.found = 1'b1;
                    r.slot = SLOT_W'(hit);
                end else begin
                    if (used_count < NUM_ENTRIES) begin
                        victim = used_count;
                        used_count++;
                    end else begin
                        // lowest index among the strictly oldest stamps
                        victim = 0;
                        oldest = stamp_mem[0];
                        for (int i = 1; i < NUM_ENTRIES; i++) begin
                            if (stamp_mem[i] < oldest) begin
                                oldest = stamp_mem[i];
                                victim = i;
                            end
                        end
                        if (link) begin
                            r.release_valid = 1'b1;
                            r.release_handle = name_mem[victim];
                        end
                    end
                    tag_mem[victim] = key;
                    name_mem[victim] = hnd;
                    stamp_mem[victim] = now;
                    r.slot = SLOT_W'(victim);
                end
                pending_results.push_back(r);
            end
            MODE_CLEAR: begin
                if (link && used_count > 0) begin
                    for (int i = 0; i < used_count; i++) begin
                        r = '0;
                        r.slot = SLOT_W'(i);
                        r.release_valid = 1'b1;
                        r.release_handle = name_mem[i];
                        r.last = (i == used_count - 1);
                        pending_results.push_back(r);
                    end
                end else begin
                    pending_results.push_back(r);
                end
                used_count = 0;
            end
            default: begin
                pending_results.push_back(r);
            end
        endcase
    endtask

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 5) != 0) return 0;
        return $urandom_range(1, 19);
    endfunction

    // offer one request and hold it until accepted
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                                input logic [HPORT_W-1:0] hnd, input logic [STAMP_W-1:0] now,
                                input logic link, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_key         <= key;
        i_name_handle <= hnd;
        i_now         <= now;
        i_link_up     <= link;
        do @(posedge i_clk); while (o_stall);
        cache_access(mode, key, hnd, now, link);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    // result side: check and random stall
    initial begin
        int      stall_left;
        logic    stall_nxt;
        t_result want;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with none expected: slot %0d handle %0h", o_slot,
                           o_release_handle);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("found", want.found, o_found);
                    compare_field("slot", want.slot, o_slot);
                    compare_field("handle_out", want.handle_out, o_handle_out);
                    compare_field("release_valid", want.release_valid, o_release_valid);
                    compare_field("release_handle", want.release_handle, o_release_handle);
                    compare_field("last", want.last, o_last);
                end
            end
            if (hold_off_req) begin
                stall_left = LONG_HOLD;
                hold_off_req = 1'b0;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                stall_nxt = 1'b1;
                stall_left--;
            end else begin
                stall_nxt = 1'b0;
            end
            i_stall <= stall_nxt;
        end
    end

    // request side
    initial begin
        t_stim_row        row;
        logic [MODE_W-1:0]  rmode;
        logic [KEY_W-1:0]   rkey;
        logic [STAMP_W-1:0] clock_now;
        logic [STAMP_W-1:0] rnow;
        int               pick;

        error_count   = 0;
        cycle_count   = 0;
        used_count    = 0;
        hold_off_req  = 1'b0;
        quiet         = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_mode        <= MODE_LOOKUP;
        i_key         <= '0;
        i_name_handle <= '0;
        i_now         <= '0;
        i_link_up     <= 1'b0;

        // after reset, extremes, update in place
        directed_tbl[0]  = '{MODE_LOOKUP, 64'h0, 16'h0, 32'h0, 1'b1, 6'd1, 1'b1, DONE_ONLY};
        directed_tbl[1]  = '{MODE_CLEAR, 64'h0, 16'h0, 32'h0, 1'b1, 6'd1, 1'b1, DONE_ONLY};
        directed_tbl[2]  = '{MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                             1'b1, 6'd1, 1'b1, DONE_ONLY};
        directed_tbl[3]  = '{MODE_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                             1'b1, 6'd1, 1'b1, DONE_ONLY};
        directed_tbl[4]  = '{MODE_ADD, 64'h0, 16'h0, 32'h0, 1'b0, 6'd1, 1'b1,
                             '{1'b0, 5'd1, 16'h0, 1'b0, 16'h0, 1'b1}};
        directed_tbl[5]  = '{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 32'd7, 1'b1, 6'd1,
                             1'b1, '{1'b1, 5'd0, 16'hFFFF, 1'b0, 16'h0, 1'b1}};
        directed_tbl[6]  = '{MODE_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234, 32'd7, 1'b1, 6'd1,
                             1'b1, '{1'b1, 5'd0, 16'h0, 1'b0, 16'h0, 1'b1}};
        directed_tbl[7]  = '{MODE_LOOKUP, 64'h0, 16'h0, 32'h0, 1'b1, 6'd1, 1'b1,
                             '{1'b1, 5'd1, 16'h0, 1'b0, 16'h0, 1'b1}};
        // fill the rest of the table with equal stamps
        directed_tbl[8]  = '{MODE_ADD, 64'h100, 16'h100, 32'd5, 1'b1, 6'd30, 1'b0, DONE_ONLY};
        // eviction with link down, then a tie on the oldest stamp
        directed_tbl[9]  = '{MODE_ADD, 64'hA5A5_A5A5_A5A5_A5A5, 16'hAAAA, 32'd9, 1'b0, 6'd1,
                             1'b0, DONE_ONLY};
        directed_tbl[10] = '{MODE_ADD, 64'h5A5A_5A5A_5A5A_5A5A, 16'h5555, 32'd9, 1'b1, 6'd1,
                             1'b0, DONE_ONLY};
        directed_tbl[11] = '{MODE_LOOKUP, 64'h100, 16'h0, 32'd10, 1'b1, 6'd1, 1'b0, DONE_ONLY};
        directed_tbl[12] = '{MODE_LOOKUP, 64'h101, 16'h0, 32'h8000_0000, 1'b1, 6'd1, 1'b0,
                             DONE_ONLY};
        // full clear with releases
        directed_tbl[13] = '{MODE_CLEAR, 64'h0, 16'h0, 32'h0, 1'b1, 6'd1, 1'b0, DONE_ONLY};
        directed_tbl[14] = '{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 32'd11, 1'b1, 6'd1,
                             1'b1, DONE_ONLY};
        directed_tbl[15] = '{MODE_ADD, 64'h1, 16'h1, 32'd1, 1'b1, 6'd1, 1'b1, DONE_ONLY};
        // clear with link down
        directed_tbl[16] = '{MODE_CLEAR, 64'h0, 16'h0, 32'h0, 1'b0, 6'd1, 1'b1, DONE_ONLY};

        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = directed_tbl[r];
            for (int k = 0; k < row.reps; k++) begin
                send_request(row.mode, row.key + KEY_W'(k), row.hnd + HPORT_W'(k), row.now,
                             row.link, pick_gap());
                if (row.use_lit) begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(row.lit);
                end
            end
        end

        // random part: a small key pool keeps hits and evictions frequent
        clock_now = $urandom;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == HOLD_AT) hold_off_req = 1'b1;
            if (n == QUIET_AT) quiet = 1'b1;
            if (n == PAUSE_AT) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) rmode = MODE_LOOKUP;
            else if (pick < 98) rmode = MODE_ADD;
            else if (pick == 98) rmode = MODE_UNUSED;
            else rmode = MODE_CLEAR;
            if ($urandom_range(0, 99) < 85) rkey = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else rkey = {$urandom, $urandom};
            clock_now = clock_now + STAMP_W'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0) rnow = $urandom;
            else rnow = clock_now;
            send_request(rmode, rkey, HPORT_W'($urandom), rnow, $urandom_range(0, 9) != 0,
                         (n == PAUSE_AT) ? 0 : pick_gap());
        end
        i_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
